// ===== rtl/core/pta_pkg.sv =====
package pta_pkg;

   localparam int MAC_W   = 48;
   localparam int TIME_W  = 32;
   localparam int AGE_W   = 22;
   localparam int COUNT_W = 5;

   localparam logic [AGE_W-1:0]   PRUNE_AGE_RESET = AGE_W'(60000);
   localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_PRUNE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_REFRESH = 2'd0,
      OP_INSERT  = 2'd1,
      OP_REMOVE  = 2'd2
   } commit_op_type;

   // request walking down the cell chain
   typedef struct packed {
      logic               active;
      cmd_type            cmd;
      logic [MAC_W-1:0]   mac;
      logic [TIME_W-1:0]  now;
      logic               found;
      logic               free_found;
      logic [TIME_W-1:0]  seen;
      logic [COUNT_W-1:0] count;
   } probe_type;

   // table update broadcast to all cells after the walk
   typedef struct packed {
      logic              en;
      commit_op_type     op;
      logic [MAC_W-1:0]  mac;
      logic [TIME_W-1:0] now;
   } commit_type;

endpackage

// ===== rtl/core/pta_cell.sv =====
module pta_cell import pta_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  probe_type        probe_in,
   input  logic [AGE_W-1:0] age_limit,
   input  commit_type       commit,
   output probe_type        probe_out
);

   logic              valid_ff, valid_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [TIME_W-1:0] seen_ff, seen_in;
   logic              match_ff, match_in;
   logic              free_ff, free_in;
   probe_type         probe_ff, probe_in_next;

   logic              key_hit;
   logic              first_free;
   logic              aged;
   logic [TIME_W-1:0] age;

   always_comb begin
      key_hit    = valid_ff && (probe_in.mac == mac_ff) && (probe_in.cmd != CMD_PRUNE);
      first_free = !valid_ff && !probe_in.free_found;
      age        = probe_in.now - seen_ff;
      aged       = valid_ff && (age > {{(TIME_W-AGE_W){1'b0}}, age_limit});

      probe_in_next = probe_in;
      if (probe_in.active) begin
         if (key_hit) begin
            probe_in_next.found = 1'b1;
            probe_in_next.seen  = seen_ff;
         end
         if (first_free) begin
            probe_in_next.free_found = 1'b1;
         end
         if (probe_in.cmd == CMD_PRUNE && aged && probe_in.count != COUNT_MAX) begin
            probe_in_next.count = probe_in.count + COUNT_W'(1);
         end
      end

      valid_in = valid_ff;
      mac_in   = mac_ff;
      seen_in  = seen_ff;
      match_in = probe_in.active ? key_hit : match_ff;
      free_in  = probe_in.active ? first_free : free_ff;

      if (probe_in.active && probe_in.cmd == CMD_PRUNE && aged) begin
         valid_in = 1'b0;
      end
      if (commit.en) begin
         unique case (commit.op)
            OP_REFRESH: begin
               if (match_ff) seen_in = commit.now;
            end
            OP_INSERT: begin
               if (free_ff) begin
                  valid_in = 1'b1;
                  mac_in   = commit.mac;
                  seen_in  = commit.now;
               end
            end
            OP_REMOVE: begin
               if (match_ff) valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         free_ff  <= free_in;
         probe_ff <= probe_in_next;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff  <= mac_in;
      seen_ff <= seen_in;
   end

   assign probe_out = probe_ff;

endmodule

// ===== rtl/core/peer_table_with_aging_core.sv =====
// Peer table with aging: TABLE_ENTRIES peers keyed by 48-bit MAC, each with a
// last-seen time in ms.
// Request channel (req_*): command (add/refresh, remove, find, prune), MAC
// and current time. Response channel (rsp_*): status, hit, last-seen time
// and pruned count, exactly one response per request.
// csr_wr_en/csr_wr_data write the prune age limit (reset value 60000 ms);
// write it only while no request is in flight.
// Each request walks a chain of cells, one entry per cell, one cell per
// cycle; add, refresh and remove are then applied to all cells at once.
// The request is registered in each cell's probe register in turn, then in
// the pending register, then in the response register once it is free.
// A new request is accepted only after the previous walk has finished and
// its response has been registered; req_ready is high only between walks.
// A finished walk waits for the response register to be free, so a stalled
// receiver holds off the next accept but no response is lost.
// Reset (synchronous, active high) empties the table at once and restores
// the default age limit.
module peer_table_with_aging_core import pta_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [MAC_W-1:0]  req_mac_address,
   input  logic [TIME_W-1:0] req_now_ms,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_hit,
   output logic [TIME_W-1:0] rsp_last_seen_ms,
   output logic [COUNT_W-1:0] rsp_pruned_count,
   input  logic              csr_wr_en,
   input  logic [AGE_W-1:0]  csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type          state_ff;
   probe_type          pend_ff;
   logic [AGE_W-1:0]   age_limit_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_hit_ff;
   logic [TIME_W-1:0]  rsp_seen_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   probe_type  probe [TABLE_ENTRIES+1];
   commit_type commit;
   logic       slot_free;
   status_type status_in;
   logic       hit_in;
   logic [TIME_W-1:0]  seen_in;
   logic [COUNT_W-1:0] count_in;

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      probe[0]            = '0;
      probe[0].active     = req_valid && req_ready;
      probe[0].cmd        = cmd_type'(req_command);
      probe[0].mac        = req_mac_address;
      probe[0].now        = req_now_ms;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      pta_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (probe[i]),
         .age_limit (age_limit_ff),
         .commit    (commit),
         .probe_out (probe[i+1])
      );
   end

   always_comb begin
      commit.en  = 1'b0;
      commit.op  = (pend_ff.cmd == CMD_REMOVE) ? OP_REMOVE :
                   (pend_ff.found ? OP_REFRESH : OP_INSERT);
      commit.mac = pend_ff.mac;
      commit.now = pend_ff.now;
      if (state_ff == S_DONE && slot_free) begin
         commit.en = (pend_ff.cmd == CMD_ADD && (pend_ff.found || pend_ff.free_found)) ||
                     (pend_ff.cmd == CMD_REMOVE && pend_ff.found);
      end
   end

   always_comb begin
      status_in = ST_OK;
      hit_in    = 1'b0;
      seen_in   = '0;
      count_in  = '0;
      unique case (pend_ff.cmd)
         CMD_ADD: begin
            hit_in = pend_ff.found;
            if (!pend_ff.found && !pend_ff.free_found) status_in = ST_FULL;
         end
         CMD_REMOVE, CMD_FIND: begin
            hit_in = pend_ff.found;
            if (!pend_ff.found) status_in = ST_NOT_FOUND;
            if (pend_ff.cmd == CMD_FIND && pend_ff.found) seen_in = pend_ff.seen;
         end
         CMD_PRUNE: begin
            count_in = pend_ff.count;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_WALK;
            end
            S_WALK: begin
               if (probe[TABLE_ENTRIES].active) begin
                  pend_ff  <= probe[TABLE_ENTRIES];
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_hit_ff    <= hit_in;
                  rsp_seen_ff   <= seen_in;
                  rsp_count_ff  <= count_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= PRUNE_AGE_RESET;
      end else if (csr_wr_en) begin
         age_limit_ff <= csr_wr_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_last_seen_ms = rsp_seen_ff;
   assign rsp_pruned_count = rsp_count_ff;

endmodule

// ===== rtl/core/pta_checker.sv =====
module pta_checker import pta_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic               rsp_hit,
   input logic [TIME_W-1:0]  rsp_last_seen_ms,
   input logic [COUNT_W-1:0] rsp_pruned_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_hit) &&
      $stable(rsp_last_seen_ms) && $stable(rsp_pruned_count))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)
      else $error("bad response status");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> !rsp_hit && rsp_pruned_count == '0 &&
      rsp_last_seen_ms == '0)
      else $error("table full response carries data");

   a_prune_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pruned_count != '0 |-> rsp_status == ST_OK && !rsp_hit)
      else $error("prune response with hit or error");

   a_seen_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_seen_ms != '0 |-> rsp_hit && rsp_status == ST_OK)
      else $error("last seen time without hit");

endmodule

bind peer_table_with_aging_core pta_checker u_pta_checker (.*);

// ===== verif/peer_table_checker.sv =====
module peer_table_checker import pta_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [MAC_W-1:0]   req_mac_address,
   input  logic [TIME_W-1:0]  req_now_ms,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_hit,
   input  logic [TIME_W-1:0]  rsp_last_seen_ms,
   input  logic [COUNT_W-1:0] rsp_pruned_count,
   input  logic               csr_wr_en,
   input  logic [AGE_W-1:0]   csr_wr_data,
   output int                 error_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type         status;
      logic               hit;
      logic [TIME_W-1:0]  seen;
      logic [COUNT_W-1:0] count;
   } peer_reply_type;

   peer_reply_type    reply_queue[$];
   logic              peer_valid [TABLE_ENTRIES];
   logic [MAC_W-1:0]  peer_mac   [TABLE_ENTRIES];
   logic [TIME_W-1:0] peer_seen  [TABLE_ENTRIES];
   logic [AGE_W-1:0]  age_limit;

   initial begin
      error_count = 0;
      pending = 0;
   end

   function automatic peer_reply_type apply_request(cmd_type cmd, logic [MAC_W-1:0] mac,
                                                    logic [TIME_W-1:0] now);
      peer_reply_type r;
      int match;
      logic [TIME_W-1:0] age;
      r = '{status: ST_OK, hit: 1'b0, seen: '0, count: '0};
      match = -1;
      if (cmd == CMD_PRUNE) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (peer_valid[i]) begin
               age = now - peer_seen[i];
               if (age > TIME_W'(age_limit)) begin
                  peer_valid[i] = 1'b0;
                  if (r.count != COUNT_MAX) r.count = r.count + 1'b1;
               end
            end
         end
         return r;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (match < 0 && peer_valid[i] && peer_mac[i] == mac) match = i;
      end
      if (cmd == CMD_ADD) begin
         if (match >= 0) begin
            peer_seen[match] = now;
            r.hit = 1'b1;
         end else begin
            r.status = ST_FULL;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (r.status == ST_FULL && !peer_valid[i]) begin
                  peer_valid[i] = 1'b1;
                  peer_mac[i] = mac;
                  peer_seen[i] = now;
                  r.status = ST_OK;
               end
            end
         end
      end else if (match < 0) begin
         r.status = ST_NOT_FOUND;
      end else begin
         r.hit = 1'b1;
         if (cmd == CMD_REMOVE) peer_valid[match] = 1'b0;
         else r.seen = peer_seen[match];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      peer_reply_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) peer_valid[i] = 1'b0;
         age_limit = PRUNE_AGE_RESET;
         reply_queue.delete();
      end else begin
         if (csr_wr_en) age_limit = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (reply_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: response with no request outstanding: status %0d hit %0d",
                           $realtime, rsp_status, rsp_hit);
            end else begin
               want = reply_queue.pop_front();
               if (want.status != rsp_status || want.hit != rsp_hit ||
                   want.seen != rsp_last_seen_ms || want.count != rsp_pruned_count) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: mismatch: expected status %0d hit %0d seen %h count %0d,",
                               " got status %0d hit %0d seen %h count %0d"},
                              $realtime, want.status, want.hit, want.seen, want.count,
                              rsp_status, rsp_hit, rsp_last_seen_ms, rsp_pruned_count);
               end
            end
         end
         if (req_valid && req_ready)
            reply_queue.push_back(apply_request(cmd_type'(req_command), req_mac_address,
                                                req_now_ms));
      end
      pending <= reply_queue.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import pta_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_ENTRIES = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int POOL_SIZE     = 20;
   localparam int PHASE_ITEMS   = 115;
   localparam logic [MAC_W-1:0] MAC_ONES = '1;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_command;
   logic [MAC_W-1:0]   req_mac_address;
   logic [TIME_W-1:0]  req_now_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic               rsp_hit;
   logic [TIME_W-1:0]  rsp_last_seen_ms;
   logic [COUNT_W-1:0] rsp_pruned_count;
   logic               csr_wr_en;
   logic [AGE_W-1:0]   csr_wr_data;

   int                 error_count;
   int                 pending;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   bit                 no_gaps = 0;
   logic [MAC_W-1:0]   peer_pool[POOL_SIZE];
   logic [TIME_W-1:0]  now_t;

   always #10 clock = ~clock;

   peer_table_with_aging_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (.*);

   peer_table_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) peer_check (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: changing stall patterns plus a periodic long hold-off
   initial begin
      int rcv_cycle;
      int hold_left;
      int seg_left;
      int pattern;
      rcv_cycle = 0;
      hold_left = 0;
      seg_left = 0;
      pattern = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rcv_cycle++;
         if (seg_left == 0) begin
            pattern = $urandom_range(0, 2);
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rcv_cycle % 4000 == 1500) begin
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic issue(cmd_type cmd, logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now);
      int gap;
      if (burst_left == 0) begin
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_mac_address <= mac;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_age(logic [AGE_W-1:0] age);
      drain();
      repeat (TABLE_ENTRIES + 4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= age;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      logic [MAC_W-1:0] m;
      m[31:0] = $urandom();
      m[MAC_W-1:32] = 16'($urandom());
      return m;
   endfunction

   task automatic random_phase(logic [AGE_W-1:0] age);
      logic [TIME_W-1:0] step_max;
      logic [MAC_W-1:0] mac;
      cmd_type cmd;
      int r;
      step_max = TIME_W'(age >> 5) + 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         no_gaps = (k % 100) < 25;
         if (k == PHASE_ITEMS / 2) drain();
         r = $urandom_range(0, 99);
         cmd = r < 45 ? CMD_ADD : r < 60 ? CMD_REMOVE : r < 85 ? CMD_FIND : CMD_PRUNE;
         if ($urandom_range(0, 99) < 85) mac = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
         else mac = random_mac();
         if ($urandom_range(0, 39) == 0) now_t = $urandom();
         else if ($urandom_range(0, 4) != 0) now_t = now_t + $urandom_range(0, step_max);
         issue(cmd, mac, now_t);
      end
   endtask

   initial begin
      logic [AGE_W-1:0] phase_age[6];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_ADD;
      req_mac_address <= '0;
      req_now_ms <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      for (int i = 0; i < POOL_SIZE; i++) peer_pool[i] = random_mac();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset age limit
      issue(CMD_FIND, peer_pool[0], 32'd1000);
      issue(CMD_REMOVE, peer_pool[0], 32'd1000);
      issue(CMD_PRUNE, peer_pool[0], 32'd1000);
      issue(CMD_ADD, '0, 32'd1000);
      issue(CMD_ADD, MAC_ONES, 32'd1005);
      issue(CMD_ADD, '0, 32'd1010);
      issue(CMD_FIND, '0, 32'd1011);
      issue(CMD_REMOVE, MAC_ONES, 32'd1012);
      issue(CMD_FIND, MAC_ONES, 32'd1013);
      for (int i = 0; i < TABLE_ENTRIES - 1; i++) issue(CMD_ADD, peer_pool[i], 32'(1020 + i));
      issue(CMD_ADD, peer_pool[TABLE_ENTRIES - 1], 32'd1040);
      issue(CMD_PRUNE, '0, 32'hFFFF_FFFF);
      // age equal to the limit is kept, one more is freed
      issue(CMD_ADD, peer_pool[0], 32'd100);
      issue(CMD_PRUNE, MAC_ONES, 32'd60100);
      issue(CMD_PRUNE, MAC_ONES, 32'd60101);

      // zero limit, with an entry whose age wraps
      write_age('0);
      issue(CMD_ADD, peer_pool[1], 32'hFFFF_FFF0);
      issue(CMD_ADD, peer_pool[2], 32'd5);
      issue(CMD_PRUNE, '0, 32'd5);
      issue(CMD_FIND, peer_pool[2], 32'd5);

      phase_age[0] = '0;
      phase_age[1] = AGE_W'(1);
      phase_age[2] = AGE_W'(3600000);
      phase_age[3] = '1;
      phase_age[4] = AGE_W'($urandom_range(1, 3600000));
      phase_age[5] = PRUNE_AGE_RESET;
      now_t = 32'd10;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) write_age(phase_age[p]);
         random_phase(phase_age[p]);
      end

      drain();
      repeat (4 * TABLE_ENTRIES) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
